// File: rtl/kbdi_pkg.sv
package kbdi_pkg;

    // Result kinds, carried on the master-side tuser.
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_SEG    = 2'd1;
    localparam logic [1:0] KIND_LAMP   = 2'd2;
    localparam logic [1:0] KIND_ACCEPT = 2'd3;

    // Command byte mode field and its codes.
    localparam logic [7:0] MODE_MASK          = 8'he0;
    localparam logic [7:0] MODE_SWITCH_READ   = 8'h40;
    localparam logic [7:0] MODE_DISPLAY_READ  = 8'h60;
    localparam logic [7:0] MODE_DISPLAY_WRITE = 8'h80;

    // Status lamp bits that together select the replay display.
    localparam logic [7:0] REPLAY_LAMP_MASK = 8'h11;

    // Register pointer values that have side effects.
    localparam logic [3:0] PTR_STATUS   = 4'd2;
    localparam logic [3:0] PTR_ZERO_A   = 4'd6;
    localparam logic [3:0] PTR_ZERO_B   = 4'd7;
    localparam logic [3:0] PTR_LAMP_A   = 4'd8;
    localparam logic [3:0] PTR_LAMP_B   = 4'd9;
    localparam logic [3:0] PTR_MILLION  = 4'd10;

    // Fixed segment and lamp positions.
    localparam logic [5:0] SEG_NORMAL_HI  = 6'd15;
    localparam logic [5:0] SEG_NORMAL_LO  = 6'd31;
    localparam logic [5:0] SEG_REPLAY     = 6'd40;
    localparam logic [5:0] SEG_STATUS_A   = 6'd32;
    localparam logic [5:0] SEG_MILLION_A  = 6'd33;
    localparam logic [5:0] SEG_MILLION_B  = 6'd34;
    localparam logic [5:0] SEG_STATUS_B   = 6'd35;
    localparam logic [5:0] SEG_ZERO       = 6'd36;
    localparam logic [5:0] LAMP_STATUS    = 6'd8;
    localparam logic [5:0] LAMP_A         = 6'd9;
    localparam logic [5:0] LAMP_B         = 6'd10;
    localparam logic [5:0] LAMP_MILLION   = 6'd11;

    localparam int unsigned MAX_RESULTS = 5;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] target_index;
        logic [7:0] value;
    } t_result;

    // BCD digit to seven-segment pattern, bit0 is segment a. Codes above nine blank.
    function automatic logic [7:0] seg_font(input logic [3:0] digit);
        logic [7:0] pattern;
        case (digit)
            4'd0:    pattern = 8'h3f;
            4'd1:    pattern = 8'h06;
            4'd2:    pattern = 8'h5b;
            4'd3:    pattern = 8'h4f;
            4'd4:    pattern = 8'h66;
            4'd5:    pattern = 8'h6d;
            4'd6:    pattern = 8'h7c;
            4'd7:    pattern = 8'h07;
            4'd8:    pattern = 8'h7f;
            4'd9:    pattern = 8'h67;
            default: pattern = 8'h00;
        endcase
        return pattern;
    endfunction

endpackage

// File: rtl/keyboard_display_interface_unit.sv
// Keyboard/display interface unit, bus side of a keyboard/display controller.
// The first result of an item is presented in the cycle after the item is accepted.
// Items with a single result are taken one item per cycle while the output accepts every result;
// an item with N results (N up to 5) holds the result buffer until all N have left the output.
// Reset: synchronous, active low; clears command, pointer, read byte, lamp byte, digit flag,
// the replay disable register and the result count (the buffer slots are not reset).
module keyboard_display_interface_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration write channel: replay_display_disable.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,

    // Bus access items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [7:0] write_data, [71:8] switch_matrix
    input  logic [1:0]  s_axis_tuser,   // [0] cmd, [1] port_select

    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [5:0] target_index, [13:6] value, [15:14] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);

    // Architectural state of the controller.
    logic        r_replay_disable;
    logic [7:0]  r_command;
    logic [3:0]  r_pointer;
    logic [7:0]  r_last_read;
    logic [7:0]  r_status_lamp;
    logic        r_digit36_done;

    // Result buffer: slot 0 is the item on the output, later slots shift down.
    kbdi_pkg::t_result r_slot [kbdi_pkg::MAX_RESULTS];
    logic [2:0]        r_count;

    // Next values, computed from the incoming item and the present state.
    kbdi_pkg::t_result n_slot [kbdi_pkg::MAX_RESULTS];
    logic [2:0]        n_count;
    logic [7:0]        n_command;
    logic [3:0]        n_pointer;
    logic [7:0]        n_last_read;
    logic [7:0]        n_status_lamp;
    logic              n_digit36_done;

    logic              in_accept;
    logic              out_accept;
    logic              in_write;
    logic              in_port_cmd;
    logic [7:0]        in_data;
    logic [63:0]       in_switch;
    logic [7:0]        mode;
    logic [3:0]        ptr_step;
    logic [7:0]        digit_hi;
    logic [7:0]        digit_lo;
    logic [7:0]        digit_one;
    logic              replay_path;
    kbdi_pkg::t_result extra [3];
    logic [1:0]        extra_count;

    assign in_write    = s_axis_tuser[0];
    assign in_port_cmd = s_axis_tuser[1];
    assign in_data     = s_axis_tdata[7:0];
    assign in_switch   = s_axis_tdata[71:8];

    // A new item may enter when the buffer is empty or its last result leaves now.
    assign s_axis_tready = (r_count == 3'd0) || ((r_count == 3'd1) && m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_accept    = m_axis_tvalid && m_axis_tready;

    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = (r_count != 3'd0);
    assign m_axis_tlast  = (r_count == 3'd1);
    assign m_axis_tuser  = r_slot[0].kind;
    assign m_axis_tdata  = {2'b00, r_slot[0].value, r_slot[0].target_index};

    assign mode      = r_command & kbdi_pkg::MODE_MASK;
    // The pointer wraps at sixteen, which the 4-bit add gives for free.
    assign ptr_step  = r_command[4] ? (r_pointer + 4'd1) : r_pointer;
    assign digit_hi  = kbdi_pkg::seg_font(in_data[7:4]);
    assign digit_lo  = kbdi_pkg::seg_font(in_data[3:0]);
    assign digit_one = kbdi_pkg::seg_font(4'd1);
    // The replay path looks at the lamp byte as it stood before this write.
    assign replay_path = !r_replay_disable &&
                         ((r_status_lamp & kbdi_pkg::REPLAY_LAMP_MASK)
                          == kbdi_pkg::REPLAY_LAMP_MASK);

    // Side results of a display write that depend on the pointer value.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            extra[i] = '{kind: kbdi_pkg::KIND_SEG, target_index: 6'd0, value: 8'd0};
        end
        extra_count    = 2'd0;
        n_status_lamp  = r_status_lamp;
        n_digit36_done = r_digit36_done;
        case (r_pointer)
            kbdi_pkg::PTR_STATUS: begin
                n_status_lamp = in_data;
                extra[0] = '{kind: kbdi_pkg::KIND_LAMP, target_index: kbdi_pkg::LAMP_STATUS,
                             value: in_data};
                extra[1] = '{kind: kbdi_pkg::KIND_SEG, target_index: kbdi_pkg::SEG_STATUS_A,
                             value: in_data[6] ? digit_one : 8'd0};
                extra[2] = '{kind: kbdi_pkg::KIND_SEG, target_index: kbdi_pkg::SEG_STATUS_B,
                             value: in_data[2] ? digit_one : 8'd0};
                extra_count = 2'd3;
            end
            kbdi_pkg::PTR_ZERO_A, kbdi_pkg::PTR_ZERO_B: begin
                if (!r_digit36_done) begin
                    n_digit36_done = 1'b1;
                    extra[0] = '{kind: kbdi_pkg::KIND_SEG, target_index: kbdi_pkg::SEG_ZERO,
                                 value: kbdi_pkg::seg_font(4'd0)};
                    extra_count = 2'd1;
                end
            end
            kbdi_pkg::PTR_LAMP_A: begin
                extra[0] = '{kind: kbdi_pkg::KIND_LAMP, target_index: kbdi_pkg::LAMP_A,
                             value: in_data};
                extra_count = 2'd1;
            end
            kbdi_pkg::PTR_LAMP_B: begin
                extra[0] = '{kind: kbdi_pkg::KIND_LAMP, target_index: kbdi_pkg::LAMP_B,
                             value: in_data};
                extra_count = 2'd1;
            end
            kbdi_pkg::PTR_MILLION: begin
                extra[0] = '{kind: kbdi_pkg::KIND_LAMP, target_index: kbdi_pkg::LAMP_MILLION,
                             value: in_data};
                extra[1] = '{kind: kbdi_pkg::KIND_SEG, target_index: kbdi_pkg::SEG_MILLION_A,
                             value: in_data[6] ? digit_one : 8'd0};
                extra[2] = '{kind: kbdi_pkg::KIND_SEG, target_index: kbdi_pkg::SEG_MILLION_B,
                             value: in_data[2] ? digit_one : 8'd0};
                extra_count = 2'd3;
            end
            default: begin
                extra_count = 2'd0;
            end
        endcase
    end

    // One pass over the access: next state and the full list of results.
    always_comb begin
        for (int i = 0; i < kbdi_pkg::MAX_RESULTS; i++) begin
            n_slot[i] = '{kind: kbdi_pkg::KIND_ACCEPT, target_index: 6'd0, value: 8'd0};
        end
        n_count     = 3'd1;
        n_command   = r_command;
        n_pointer   = r_pointer;
        n_last_read = r_last_read;

        if (!in_write) begin
            // Read: a switch column, a blank display byte, or the previous byte again.
            if (mode == kbdi_pkg::MODE_SWITCH_READ) begin
                n_last_read = in_switch[{r_command[2:0], 3'b000} +: 8];
            end else if (mode == kbdi_pkg::MODE_DISPLAY_READ) begin
                n_last_read = 8'd0;
            end
            n_pointer = ptr_step;
            n_slot[0] = '{kind: kbdi_pkg::KIND_READ, target_index: 6'd0, value: n_last_read};
        end else if (in_port_cmd) begin
            n_command = in_data;
            if (in_data[4]) begin
                n_pointer = in_data[3:0];
            end
        end else begin
            n_pointer = ptr_step;
            if (mode == kbdi_pkg::MODE_DISPLAY_WRITE) begin
                if (replay_path) begin
                    n_slot[0] = '{kind: kbdi_pkg::KIND_SEG,
                                  target_index: kbdi_pkg::SEG_REPLAY + {2'b00, r_pointer},
                                  value: digit_hi};
                    n_slot[1] = extra[0];
                    n_slot[2] = extra[1];
                    n_slot[3] = extra[2];
                    n_count   = 3'd1 + {1'b0, extra_count};
                end else begin
                    // Normal digits sit at mirrored positions of the two display rows.
                    n_slot[0] = '{kind: kbdi_pkg::KIND_SEG,
                                  target_index: kbdi_pkg::SEG_NORMAL_HI - {2'b00, r_pointer},
                                  value: digit_hi};
                    n_slot[1] = '{kind: kbdi_pkg::KIND_SEG,
                                  target_index: kbdi_pkg::SEG_NORMAL_LO - {2'b00, r_pointer},
                                  value: digit_lo};
                    n_slot[2] = extra[0];
                    n_slot[3] = extra[1];
                    n_slot[4] = extra[2];
                    n_count   = 3'd2 + {1'b0, extra_count};
                end
            end
        end
    end

    // State registers and the result buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replay_disable <= 1'b0;
            r_command        <= 8'd0;
            r_pointer        <= 4'd0;
            r_last_read      <= 8'd0;
            r_status_lamp    <= 8'd0;
            r_digit36_done   <= 1'b0;
            r_count          <= 3'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_replay_disable <= i_cfg_data;
            end
            if (in_accept) begin
                r_command   <= n_command;
                r_pointer   <= n_pointer;
                r_last_read <= n_last_read;
                r_count     <= n_count;
                // Lamp byte and digit flag change only on display-mode data writes.
                if (in_write && !in_port_cmd && (mode == kbdi_pkg::MODE_DISPLAY_WRITE)) begin
                    r_status_lamp  <= n_status_lamp;
                    r_digit36_done <= n_digit36_done;
                end
            end else if (out_accept) begin
                r_count <= r_count - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            for (int i = 0; i < kbdi_pkg::MAX_RESULTS; i++) begin
                r_slot[i] <= n_slot[i];
            end
        end else if (out_accept) begin
            for (int i = 0; i < kbdi_pkg::MAX_RESULTS - 1; i++) begin
                r_slot[i] <= r_slot[i + 1];
            end
        end
    end

    // A new item is only taken while the buffer drains its final result or is empty.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tready && m_axis_tvalid) |-> m_axis_tlast)
        else $error("item accepted while more than one result was pending");

    // The buffer never holds more results than one access can cause.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(kbdi_pkg::MAX_RESULTS))
        else $error("result buffer count out of range");

    // Every accepted item shows a result in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> m_axis_tvalid)
        else $error("accepted item produced no result");

    // A command write answers with a single write-accepted result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_write && in_port_cmd) |=>
            (m_axis_tlast && (m_axis_tuser == kbdi_pkg::KIND_ACCEPT)))
        else $error("command write result malformed");

endmodule

// File: verif/tb.sv
module tb;

    localparam int unsigned RESET_CYCLES    = 11;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned SETTLE_CYCLES   = 16;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS     = 82;
    localparam int unsigned PHASE_COUNT     = 5;

    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;
    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_CMD  = 1'b1;

    // Command byte bit that makes data accesses step the register pointer.
    localparam logic [7:0] AUTO_INC   = 8'h10;
    // A mode with no read or write function of its own.
    localparam logic [7:0] MODE_OTHER = 8'h20;

    // Seven-segment patterns of digits 0..15, digit d in bits [8d+7:8d]; 10..15 blank.
    localparam logic [127:0] DIGIT_SEGS = {
        48'h0,
        8'h67, 8'h7f, 8'h07, 8'h7c, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
    };

    typedef struct packed {
        logic        wr;
        logic        port;
        logic [7:0]  data;
        logic [63:0] sw;
    } t_access;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] target_index;
        logic [7:0] value;
        logic       last;
    } t_expect;

    // One row of the directed table. When has_value is set the single result is typed in.
    typedef struct packed {
        logic        wr;
        logic        port;
        logic [7:0]  data;
        logic [63:0] sw;
        logic        has_value;
        logic [1:0]  kind;
        logic [7:0]  value;
    } t_row;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data     = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata   = '0;   // [7:0] write_data, [71:8] switch_matrix
    logic [1:0]  s_axis_tuser   = '0;   // [0] cmd, [1] port_select
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [15:0] m_axis_tdata;          // [5:0] target_index, [13:6] value, [15:14] zero
    logic [1:0]  m_axis_tuser;          // [1:0] kind
    logic        m_axis_tlast;

    // Mirror of the block state used by the display predictor.
    logic [7:0]  cmd_byte    = '0;
    logic [3:0]  reg_ptr     = '0;
    logic [7:0]  read_byte   = '0;
    logic [7:0]  lamp_byte   = '0;
    logic        zero_done   = 1'b0;
    logic        replay_off  = 1'b0;

    t_expect     access_results[$];
    t_expect     pending_results[$];
    int unsigned failures     = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned rx_hold      = 0;

    keyboard_display_interface_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] digit_segs(input logic [3:0] digit);
        return DIGIT_SEGS[int'(digit) * 8 +: 8];
    endfunction

    function automatic logic [7:0] compose_command(input logic [7:0] mode, input logic inc,
                                                   input logic [3:0] low);
        return mode | (inc ? AUTO_INC : 8'h00) | {4'h0, low};
    endfunction

    function automatic void add_result(input logic [1:0] kind, input logic [5:0] idx,
                                       input logic [7:0] val);
        access_results.push_back({kind, idx, val, 1'b0});
    endfunction

    function automatic void step_pointer();
        if ((cmd_byte & AUTO_INC) != 0)
            reg_ptr = reg_ptr + 4'd1;
    endfunction

    // Works out every result of one bus access and updates the mirrored state.
    function automatic void predict_access(input t_access a);
        logic [7:0] mode;
        logic [3:0] ptr;
        logic [7:0] one_seg;
        t_expect    tail;
        access_results.delete();
        mode    = cmd_byte & kbdi_pkg::MODE_MASK;
        ptr     = reg_ptr;
        one_seg = digit_segs(4'd1);
        if (a.wr == ACC_READ) begin
            if (mode == kbdi_pkg::MODE_SWITCH_READ)
                read_byte = a.sw[int'(cmd_byte[2:0]) * 8 +: 8];
            else if (mode == kbdi_pkg::MODE_DISPLAY_READ)
                read_byte = 8'h00;
            step_pointer();
            add_result(kbdi_pkg::KIND_READ, 6'd0, read_byte);
        end else if (a.port == PORT_CMD) begin
            cmd_byte = a.data;
            if ((a.data & AUTO_INC) != 0)
                reg_ptr = a.data[3:0];
            add_result(kbdi_pkg::KIND_ACCEPT, 6'd0, 8'h00);
        end else begin
            if (mode == kbdi_pkg::MODE_DISPLAY_WRITE) begin
                // The replay view shows only the high digit, at its own positions.
                if (!replay_off && (lamp_byte & kbdi_pkg::REPLAY_LAMP_MASK)
                                   == kbdi_pkg::REPLAY_LAMP_MASK) begin
                    add_result(kbdi_pkg::KIND_SEG, kbdi_pkg::SEG_REPLAY + 6'(ptr),
                               digit_segs(a.data[7:4]));
                end else begin
                    add_result(kbdi_pkg::KIND_SEG, kbdi_pkg::SEG_NORMAL_HI - 6'(ptr),
                               digit_segs(a.data[7:4]));
                    add_result(kbdi_pkg::KIND_SEG, kbdi_pkg::SEG_NORMAL_LO - 6'(ptr),
                               digit_segs(a.data[3:0]));
                end
                case (ptr)
                    kbdi_pkg::PTR_STATUS: begin
                        lamp_byte = a.data;
                        add_result(kbdi_pkg::KIND_LAMP, kbdi_pkg::LAMP_STATUS, a.data);
                        add_result(kbdi_pkg::KIND_SEG, kbdi_pkg::SEG_STATUS_A,
                                   a.data[6] ? one_seg : 8'h00);
                        add_result(kbdi_pkg::KIND_SEG, kbdi_pkg::SEG_STATUS_B,
                                   a.data[2] ? one_seg : 8'h00);
                    end
                    kbdi_pkg::PTR_ZERO_A, kbdi_pkg::PTR_ZERO_B: begin
                        if (!zero_done) begin
                            zero_done = 1'b1;
                            add_result(kbdi_pkg::KIND_SEG, kbdi_pkg::SEG_ZERO,
                                       digit_segs(4'd0));
                        end
                    end
                    kbdi_pkg::PTR_LAMP_A:
                        add_result(kbdi_pkg::KIND_LAMP, kbdi_pkg::LAMP_A, a.data);
                    kbdi_pkg::PTR_LAMP_B:
                        add_result(kbdi_pkg::KIND_LAMP, kbdi_pkg::LAMP_B, a.data);
                    kbdi_pkg::PTR_MILLION: begin
                        add_result(kbdi_pkg::KIND_LAMP, kbdi_pkg::LAMP_MILLION, a.data);
                        add_result(kbdi_pkg::KIND_SEG, kbdi_pkg::SEG_MILLION_A,
                                   a.data[6] ? one_seg : 8'h00);
                        add_result(kbdi_pkg::KIND_SEG, kbdi_pkg::SEG_MILLION_B,
                                   a.data[2] ? one_seg : 8'h00);
                    end
                    default: ;
                endcase
            end else begin
                add_result(kbdi_pkg::KIND_ACCEPT, 6'd0, 8'h00);
            end
            step_pointer();
        end
        tail = access_results.pop_back();
        tail.last = 1'b1;
        access_results.push_back(tail);
    endfunction

    // Random accesses are mostly data writes, with command writes in between,
    // so the display-write paths and pointer side effects are reached often.
    function automatic t_access random_access();
        t_access     a;
        int unsigned pick;
        pick   = $urandom_range(99);
        a.wr   = ACC_WRITE;
        a.port = PORT_DATA;
        a.data = 8'($urandom_range(255));
        a.sw   = {$urandom, $urandom};
        if ($urandom_range(7) == 0)
            a.sw = {64{1'($urandom_range(1))}};
        if (pick < 15) begin
            a.port = PORT_CMD;
            case ($urandom_range(5))
                0, 1, 2: a.data = (a.data & ~kbdi_pkg::MODE_MASK)
                                  | kbdi_pkg::MODE_DISPLAY_WRITE;
                3:       a.data = (a.data & ~kbdi_pkg::MODE_MASK)
                                  | kbdi_pkg::MODE_SWITCH_READ;
                4:       a.data = (a.data & ~kbdi_pkg::MODE_MASK)
                                  | kbdi_pkg::MODE_DISPLAY_READ;
                default: ;
            endcase
            if ($urandom_range(3) != 0)
                a.data = a.data | AUTO_INC;
        end else if (pick < 75) begin
            if ($urandom_range(1) == 1)
                a.data = {4'($urandom_range(9)), 4'($urandom_range(9))};
        end else if (pick < 95) begin
            a.wr   = ACC_READ;
            a.port = 1'($urandom_range(1));
        end else begin
            a.wr   = 1'($urandom_range(1));
            a.port = 1'($urandom_range(1));
        end
        return a;
    endfunction

    function automatic void report_mismatch(input string field, input int unsigned want,
                                            input int unsigned got);
        failures++;
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
    endfunction

    function automatic void check_result();
        t_expect e;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result kind", 0, m_axis_tuser);
            return;
        end
        e = pending_results.pop_front();
        if (m_axis_tuser != e.kind)
            report_mismatch("kind", e.kind, m_axis_tuser);
        if (m_axis_tdata[5:0] != e.target_index)
            report_mismatch("target_index", e.target_index, m_axis_tdata[5:0]);
        if (m_axis_tdata[13:6] != e.value)
            report_mismatch("value", e.value, m_axis_tdata[13:6]);
        if (m_axis_tlast != e.last)
            report_mismatch("last", e.last, m_axis_tlast);
    endfunction

    // Result side: checks every accepted result and drives tready. A hold-off
    // request keeps tready low while rx_hold counts down, so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (rx_hold != 0) begin
                rx_hold = rx_hold - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offers one access, with random idle cycles first, and records what it should cause.
    task automatic issue_access(input t_access a, input logic has_value, input t_expect typed);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {a.sw, a.data};
        s_axis_tuser  <= {a.port, a.wr};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_access(a);
        if (has_value)
            pending_results.push_back(typed);
        else
            foreach (access_results[k]) pending_results.push_back(access_results[k]);
    endtask

    // Stops offering and waits until every pending result has been seen.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_replay_disable(input logic v);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        replay_off = v;
    endtask

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        t_row        directed[$];
        t_row        row;
        t_access     a;
        t_expect     typed;
        int unsigned phase;
        int unsigned n;

        // Reads and command writes right after reset, the read modes, then a walk
        // through the display pointer positions including wrap-around and replay.
        directed.push_back({ACC_READ, PORT_DATA, 8'h00, 64'h0,
                            1'b1, kbdi_pkg::KIND_READ, 8'h00});
        directed.push_back({ACC_WRITE, PORT_CMD,
                            compose_command(kbdi_pkg::MODE_SWITCH_READ, 1'b0, 4'd7),
                            64'h0, 1'b1, kbdi_pkg::KIND_ACCEPT, 8'h00});
        directed.push_back({ACC_READ, PORT_DATA, 8'h00, 64'hA5FF_FFFF_FFFF_FF00,
                            1'b1, kbdi_pkg::KIND_READ, 8'hA5});
        // A data write outside display-write mode is only acknowledged.
        directed.push_back({ACC_WRITE, PORT_DATA, 8'hFF, 64'h0,
                            1'b1, kbdi_pkg::KIND_ACCEPT, 8'h00});
        directed.push_back({ACC_READ, PORT_CMD, 8'h00, 64'h0,
                            1'b1, kbdi_pkg::KIND_READ, 8'h00});
        directed.push_back({ACC_WRITE, PORT_CMD,
                            compose_command(kbdi_pkg::MODE_SWITCH_READ, 1'b1, 4'd0),
                            64'h0, 1'b1, kbdi_pkg::KIND_ACCEPT, 8'h00});
        directed.push_back({ACC_READ, PORT_DATA, 8'h00, 64'hFFFF_FFFF_FFFF_FF3C,
                            1'b1, kbdi_pkg::KIND_READ, 8'h3C});
        directed.push_back({ACC_WRITE, PORT_CMD, MODE_OTHER, 64'h0,
                            1'b1, kbdi_pkg::KIND_ACCEPT, 8'h00});
        // In other modes a read repeats the previous read byte.
        directed.push_back({ACC_READ, PORT_DATA, 8'h00, {64{1'b1}},
                            1'b1, kbdi_pkg::KIND_READ, 8'h3C});
        directed.push_back({ACC_WRITE, PORT_CMD, kbdi_pkg::MODE_DISPLAY_READ, 64'h0,
                            1'b1, kbdi_pkg::KIND_ACCEPT, 8'h00});
        directed.push_back({ACC_READ, PORT_DATA, 8'h00, {64{1'b1}},
                            1'b1, kbdi_pkg::KIND_READ, 8'h00});
        directed.push_back({ACC_WRITE, PORT_CMD,
                            compose_command(kbdi_pkg::MODE_DISPLAY_WRITE, 1'b1,
                                            kbdi_pkg::PTR_STATUS),
                            64'h0, 1'b1, kbdi_pkg::KIND_ACCEPT, 8'h00});
        directed.push_back({ACC_WRITE, PORT_DATA, 8'h44, 64'h0,
                            1'b0, kbdi_pkg::KIND_READ, 8'h00});
        directed.push_back({ACC_WRITE, PORT_CMD,
                            compose_command(kbdi_pkg::MODE_DISPLAY_WRITE, 1'b1,
                                            kbdi_pkg::PTR_ZERO_A),
                            64'h0, 1'b1, kbdi_pkg::KIND_ACCEPT, 8'h00});
        directed.push_back({ACC_WRITE, PORT_DATA, 8'h99, 64'h0,
                            1'b0, kbdi_pkg::KIND_READ, 8'h00});
        directed.push_back({ACC_WRITE, PORT_DATA, 8'h12, 64'h0,
                            1'b0, kbdi_pkg::KIND_READ, 8'h00});
        directed.push_back({ACC_WRITE, PORT_DATA, 8'h80, 64'h0,
                            1'b0, kbdi_pkg::KIND_READ, 8'h00});
        directed.push_back({ACC_WRITE, PORT_DATA, 8'hFF, 64'h0,
                            1'b0, kbdi_pkg::KIND_READ, 8'h00});
        directed.push_back({ACC_WRITE, PORT_DATA, 8'h00, 64'h0,
                            1'b0, kbdi_pkg::KIND_READ, 8'h00});
        directed.push_back({ACC_WRITE, PORT_CMD,
                            compose_command(kbdi_pkg::MODE_DISPLAY_WRITE, 1'b1, 4'hF),
                            64'h0, 1'b1, kbdi_pkg::KIND_ACCEPT, 8'h00});
        directed.push_back({ACC_WRITE, PORT_DATA, 8'h5A, 64'h0,
                            1'b0, kbdi_pkg::KIND_READ, 8'h00});
        directed.push_back({ACC_WRITE, PORT_CMD,
                            compose_command(kbdi_pkg::MODE_DISPLAY_WRITE, 1'b1,
                                            kbdi_pkg::PTR_STATUS),
                            64'h0, 1'b1, kbdi_pkg::KIND_ACCEPT, 8'h00});
        // Status lamp byte with both replay bits set switches to the replay view.
        directed.push_back({ACC_WRITE, PORT_DATA, 8'h11, 64'h0,
                            1'b0, kbdi_pkg::KIND_READ, 8'h00});
        directed.push_back({ACC_WRITE, PORT_DATA, 8'h37, 64'h0,
                            1'b0, kbdi_pkg::KIND_READ, 8'h00});
        directed.push_back({ACC_WRITE, PORT_DATA, 8'hAB, 64'h0,
                            1'b0, kbdi_pkg::KIND_READ, 8'h00});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r]) begin
            row   = directed[r];
            a     = {row.wr, row.port, row.data, row.sw};
            typed = {row.kind, 6'd0, row.value, 1'b1};
            issue_access(a, row.has_value, typed);
        end

        // Random phases alternate the replay disable register and the idling pattern.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            write_replay_disable(phase[0] == 1'b0);
            case (phase)
                1:       begin tx_idle_pct = 59; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 59; end
                3:       begin tx_idle_pct = 28; rx_stall_pct = 28; end
                default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            endcase
            // Last phase: the result side holds off while accesses keep coming.
            if (phase == PHASE_COUNT - 1)
                rx_hold = HOLD_OFF_CYCLES;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                issue_access(random_access(), 1'b0, '0);
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    drain_results();
            end
        end

        drain_results();
        if (failures == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/kbdi_pkg.sv
rtl/keyboard_display_interface_unit.sv
verif/tb.sv
